// File: design/smts_pkg.sv
package smts_pkg;

   localparam logic [29:0]        NsecMax    = 30'd999999999;
   localparam logic signed [31:0] NsPerSec   = 32'sd1000000000;
   localparam logic [31:0]        OneDaySec  = 32'd86400;
   localparam logic [31:0]        EpochReset = 32'd631152000;

   typedef enum logic {
      OP_SYNC = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   // one input item, nanoseconds already saturated
   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] sys_sec;
      logic [29:0] sys_nsec;
      logic [31:0] ref_sec;
      logic [29:0] ref_nsec;
   } item_type;

endpackage

// File: design/smts_if.sv
interface smts_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] sys_sec;
   logic [29:0] sys_nsec;
   logic [31:0] ref_sec;
   logic [29:0] ref_nsec;

   modport source (output valid, opcode, sys_sec, sys_nsec, ref_sec, ref_nsec, input ready);
   modport sink   (input valid, opcode, sys_sec, sys_nsec, ref_sec, ref_nsec, output ready);
endinterface

interface smts_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_sec;
   logic [29:0] out_nsec;
   logic        held;
   logic        set_clock;

   modport source (output valid, out_sec, out_nsec, held, set_clock, input ready);
   modport sink   (input valid, out_sec, out_nsec, held, set_clock, output ready);
endinterface

// File: design/smts_in_stage.sv
module smts_in_stage (
   input  logic               clock,
   input  logic               reset,
   smts_req_if.sink           req_ch,
   input  logic               fire,
   output logic               item_valid,
   output smts_pkg::item_type item
);

   logic               valid_ff, valid_in;
   smts_pkg::item_type item_ff, item_in;
   logic               load;

   assign req_ch.ready = !valid_ff || fire;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      item_in.opcode   = smts_pkg::opcode_type'(req_ch.opcode);
      item_in.sys_sec  = req_ch.sys_sec;
      item_in.sys_nsec = (req_ch.sys_nsec > smts_pkg::NsecMax) ? smts_pkg::NsecMax
                                                                : req_ch.sys_nsec;
      item_in.ref_sec  = req_ch.ref_sec;
      item_in.ref_nsec = (req_ch.ref_nsec > smts_pkg::NsecMax) ? smts_pkg::NsecMax
                                                                : req_ch.ref_nsec;
      if (load) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: design/smts_core.sv
module smts_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [31:0]        csr_wdata,
   input  logic               item_valid,
   input  smts_pkg::item_type item,
   output logic               fire,
   smts_rsp_if.source         rsp_ch
);

   logic [31:0]        epoch_off_ff;
   logic               synced_ff;
   logic [31:0]        off_sec_ff;
   logic signed [30:0] off_nsec_ff;
   logic [31:0]        last_sec_ff;
   logic [29:0]        last_nsec_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_sec_ff;
   logic [29:0]        rsp_nsec_ff;
   logic               rsp_held_ff;
   logic               rsp_setc_ff;

   logic               is_read;
   logic               slot_free;
   logic               rd_fire;
   logic               sy_fire;
   logic signed [31:0] nsec_sum;
   logic [31:0]        sec_base;
   logic [31:0]        t_sec;
   logic [29:0]        t_nsec;
   logic               setc;
   logic               forward;

   assign is_read   = (item.opcode == smts_pkg::OP_READ);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign rd_fire   = item_valid && is_read && slot_free;
   assign sy_fire   = item_valid && !is_read;
   assign fire      = rd_fire || sy_fire;

   // after a sync t = sys + (ref - sys_at_sync), nsec brought back into one second; before, sys - epoch or one day
   always_comb begin
      nsec_sum = signed'({2'b00, item.sys_nsec}) + 32'(off_nsec_ff);
      sec_base = item.sys_sec + off_sec_ff;
      setc     = 1'b0;
      if (!synced_ff) begin
         if (item.sys_sec < epoch_off_ff) begin
            t_sec  = smts_pkg::OneDaySec;
            t_nsec = '0;
            setc   = 1'b1;
         end else begin
            t_sec  = item.sys_sec - epoch_off_ff;
            t_nsec = item.sys_nsec;
         end
      end else if (nsec_sum < 0) begin
         t_sec  = sec_base - 32'd1;
         t_nsec = 30'(nsec_sum + smts_pkg::NsPerSec);
      end else if (nsec_sum >= smts_pkg::NsPerSec) begin
         t_sec  = sec_base + 32'd1;
         t_nsec = 30'(nsec_sum - smts_pkg::NsPerSec);
      end else begin
         t_sec  = sec_base;
         t_nsec = 30'(nsec_sum);
      end
      forward = (t_sec > last_sec_ff) ||
                ((t_sec == last_sec_ff) && (t_nsec >= last_nsec_ff));

      if (rd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_off_ff <= smts_pkg::EpochReset;
         synced_ff    <= 1'b0;
         off_sec_ff   <= '0;
         off_nsec_ff  <= '0;
         last_sec_ff  <= '0;
         last_nsec_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            epoch_off_ff <= csr_wdata;
         end
         if (sy_fire) begin
            synced_ff   <= 1'b1;
            off_sec_ff  <= item.ref_sec - item.sys_sec;
            off_nsec_ff <= signed'({1'b0, item.ref_nsec}) - signed'({1'b0, item.sys_nsec});
         end
         if (rd_fire && forward) begin
            last_sec_ff  <= t_sec;
            last_nsec_ff <= t_nsec;
         end
      end
      if (rd_fire) begin
         rsp_sec_ff  <= forward ? t_sec : last_sec_ff;
         rsp_nsec_ff <= forward ? t_nsec : last_nsec_ff;
         rsp_held_ff <= !forward;
         rsp_setc_ff <= setc;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_sec   = rsp_sec_ff;
   assign rsp_ch.out_nsec  = rsp_nsec_ff;
   assign rsp_ch.held      = rsp_held_ff;
   assign rsp_ch.set_clock = rsp_setc_ff;

endmodule

// File: design/synced_monotonic_timestamp.sv
// channel  direction  handshake     payload
// req_ch   in         valid/ready   opcode, sys_sec, sys_nsec, ref_sec, ref_nsec
// rsp_ch   out        valid/ready   out_sec, out_nsec, held, set_clock
// csr      in         csr_we        csr_wdata (epoch offset)
//
// One item per cycle while rsp_ch does not stall; a read passes the input register, then its result register on rsp_ch.
// A single add/compare stage lies between the input and result registers.
// Sync items give no result and never wait on rsp_ch.
// Synchronous reset clears sync state, last reported time and both valid flags, and reloads the epoch offset.
// A stalled rsp_ch holds its item; a read waiting behind it holds req_ch until the slot frees.
module synced_monotonic_timestamp (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   smts_req_if.sink    req_ch,
   smts_rsp_if.source  rsp_ch
);

   logic               item_valid;
   smts_pkg::item_type item;
   logic               fire;

   smts_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .fire       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   smts_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .fire       (fire),
      .rsp_ch     (rsp_ch)
   );

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("input stalled while result side ready");

   a_nsec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.out_nsec <= smts_pkg::NsecMax))
      else $error("nanoseconds out of range");

   a_setclock_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.set_clock && !rsp_ch.held) |->
         (rsp_ch.out_sec == smts_pkg::OneDaySec && rsp_ch.out_nsec == '0))
      else $error("clock-set result not one day past epoch");

endmodule

// File: test/tb_synced_monotonic_timestamp.sv
module tb_synced_monotonic_timestamp;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] BILLION    = 32'd1_000_000_000;
   localparam int          CHUNK_SIZE = 200;

   typedef struct {
      logic [31:0] sec;
      logic [29:0] nsec;
      logic        held;
      logic        set_clock;
   } stamp_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;

   smts_req_if req_ch();
   smts_rsp_if rsp_ch();

   synced_monotonic_timestamp DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // timestamp model state
   logic [31:0] epoch_model;
   logic        synced_seen;
   logic [31:0] anchor_sys_sec;
   logic [29:0] anchor_sys_nsec;
   logic [31:0] anchor_ref_sec;
   logic [29:0] anchor_ref_nsec;
   logic [31:0] reported_sec;
   logic [29:0] reported_nsec;

   stamp_type expected_stamps[$];
   int        mismatches = 0;
   int        items_sent = 0;
   bit        req_gaps_on = 1'b1;
   bit        rsp_gaps_on = 1'b1;
   int        long_stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [29:0] clamp_nsec(input logic [29:0] v);
      return (v > smts_pkg::NsecMax) ? smts_pkg::NsecMax : v;
   endfunction

   function automatic logic [29:0] rand_nsec();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 30'd0;
      if (r == 1) return smts_pkg::NsecMax;
      if (r < 4) return 30'($urandom_range(32'h3FFF_FFFF, 1_000_000_000));
      return 30'($urandom_range(999_999_999, 0));
   endfunction

   function automatic int pick_idle();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic model_timestamp_item(input smts_pkg::item_type it);
      logic [31:0] s_sec, d_sec, t_sec, d_nsec, t_nsec;
      logic [29:0] s_nsec;
      stamp_type   st;
      s_sec = it.sys_sec;
      s_nsec = clamp_nsec(it.sys_nsec);
      st.held = 1'b0;
      st.set_clock = 1'b0;
      if (it.opcode == smts_pkg::OP_SYNC) begin
         anchor_sys_sec = s_sec;
         anchor_sys_nsec = s_nsec;
         anchor_ref_sec = it.ref_sec;
         anchor_ref_nsec = clamp_nsec(it.ref_nsec);
         synced_seen = 1'b1;
         return;
      end
      if (!synced_seen) begin
         if (s_sec < epoch_model) begin
            t_sec = smts_pkg::OneDaySec;
            t_nsec = 32'd0;
            st.set_clock = 1'b1;
         end else begin
            t_sec = s_sec - epoch_model;
            t_nsec = {2'b00, s_nsec};
         end
      end else begin
         if (s_nsec >= anchor_sys_nsec) begin
            d_sec = s_sec - anchor_sys_sec;
            d_nsec = {2'b00, s_nsec} - {2'b00, anchor_sys_nsec};
         end else begin
            d_sec = s_sec - anchor_sys_sec - 32'd1;
            d_nsec = BILLION - {2'b00, anchor_sys_nsec} + {2'b00, s_nsec};
         end
         t_sec = anchor_ref_sec + d_sec;
         t_nsec = {2'b00, anchor_ref_nsec} + d_nsec;
         if (t_nsec >= BILLION) begin
            t_nsec = t_nsec - BILLION;
            t_sec = t_sec + 32'd1;
         end
      end
      if (t_sec > reported_sec || (t_sec == reported_sec && t_nsec >= {2'b00, reported_nsec}))
      begin
         reported_sec = t_sec;
         reported_nsec = t_nsec[29:0];
      end else begin
         st.held = 1'b1;
      end
      st.sec = reported_sec;
      st.nsec = reported_nsec;
      expected_stamps.push_back(st);
   endtask

   task automatic send_item(input smts_pkg::opcode_type op, input logic [31:0] s_sec,
                            input logic [29:0] s_nsec, input logic [31:0] r_sec,
                            input logic [29:0] r_nsec);
      int                 gap;
      smts_pkg::item_type it;
      gap = (req_gaps_on && $urandom_range(0, 2) == 0) ? pick_idle() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.sys_sec <= s_sec;
      req_ch.sys_nsec <= s_nsec;
      req_ch.ref_sec <= r_sec;
      req_ch.ref_nsec <= r_nsec;
      // ready is stable from the falling edge to the next rising edge
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      it.opcode = op;
      it.sys_sec = s_sec;
      it.sys_nsec = s_nsec;
      it.ref_sec = r_sec;
      it.ref_nsec = r_nsec;
      model_timestamp_item(it);
      items_sent++;
   endtask

   task automatic read_time(input logic [31:0] s_sec, input logic [29:0] s_nsec);
      send_item(smts_pkg::OP_READ, s_sec, s_nsec, $urandom, 30'($urandom));
   endtask

   // block idle: no item offered, all results in, pipeline flushed
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (expected_stamps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_epoch_offset(input logic [31:0] value);
      settle_block();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      epoch_model = value;
   endtask

   // one sync, sometimes after an extra random sync, followed by a burst of reads that mostly move forward
   task automatic send_sequence();
      logic [31:0] sec, ref_base;
      int          reads;
      if ($urandom_range(0, 9) == 0)
         send_item(smts_pkg::OP_SYNC, $urandom, 30'($urandom), $urandom, 30'($urandom));
      sec = $urandom;
      ref_base = reported_sec + $urandom_range(0, 500);
      if ($urandom_range(0, 4) == 0) ref_base = reported_sec - $urandom_range(1, 60);
      send_item(smts_pkg::OP_SYNC, sec, rand_nsec(), ref_base, rand_nsec());
      reads = $urandom_range(1, 12);
      repeat (reads) begin
         if ($urandom_range(0, 6) == 0) sec = sec - $urandom_range(0, 2);
         else sec = sec + $urandom_range(0, 3);
         read_time(sec, rand_nsec());
      end
   endtask

   task automatic test_unsynced_reads();
      read_time(32'd0, 30'd0);
      read_time(smts_pkg::EpochReset, 30'd5);
      send_item(smts_pkg::OP_READ, smts_pkg::EpochReset - 32'd1, 30'h3FFF_FFFF,
                32'hFFFF_FFFF, 30'h3FFF_FFFF);
      read_time(smts_pkg::EpochReset + smts_pkg::OneDaySec, 30'd1_000_000_000);
      read_time(smts_pkg::EpochReset + smts_pkg::OneDaySec, 30'h3FFF_FFFF);
   endtask

   task automatic test_epoch_offset_extremes();
      write_epoch_offset(32'hFFFF_FFFF);
      read_time(32'hFFFF_FFFF, 30'd0);
      read_time(32'hFFFF_FFFE, 30'd7);
      write_epoch_offset(32'd0);
      read_time(smts_pkg::OneDaySec + 32'd1, 30'd0);
      read_time(32'd0, 30'd0);
   endtask

   task automatic test_unsynced_random();
      write_epoch_offset(32'hFFFF_FFFF);
      repeat (40) read_time($urandom, rand_nsec());
      write_epoch_offset(smts_pkg::EpochReset);
      repeat (60)
         read_time(epoch_model + smts_pkg::OneDaySec + $urandom_range(0, 5000), rand_nsec());
      write_epoch_offset($urandom);
      repeat (60) begin
         if ($urandom_range(0, 4) == 0)
            read_time(epoch_model - $urandom_range(1, 1000), rand_nsec());
         else
            read_time(epoch_model + smts_pkg::OneDaySec + $urandom_range(0, 5000),
                      rand_nsec());
      end
   endtask

   task automatic test_sync_arithmetic();
      send_item(smts_pkg::OP_SYNC, 32'd1000, 30'd500, 32'd1_000_000, 30'h3FFF_FFFF);
      read_time(32'd1000, 30'd500);
      read_time(32'd1000, 30'd501);
      read_time(32'd1001, 30'd499);
      read_time(32'd999, 30'd0);
      read_time(32'd1001, 30'h3FFF_FFFF);
      // second sync overwrites the first
      send_item(smts_pkg::OP_SYNC, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'd2_000_000, 30'd0);
      send_item(smts_pkg::OP_SYNC, 32'd0, 30'd0, 32'd3_000_000, 30'd0);
      read_time(32'd0, 30'd0);
      read_time(32'hFFFF_FFFF, 30'd0);
   endtask

   task automatic test_random_sequences();
      int chunk, stop_at;
      for (chunk = 0; chunk < 6; chunk++) begin
         write_epoch_offset($urandom);
         req_gaps_on = (chunk != 0) && ($urandom_range(0, 3) != 0);
         rsp_gaps_on = (chunk != 0) && ($urandom_range(0, 3) != 0);
         stop_at = items_sent + CHUNK_SIZE;
         while (items_sent < stop_at) send_sequence();
      end
   endtask

   task automatic test_result_backpressure();
      req_gaps_on = 1'b0;
      long_stall_cycles = 200;
      repeat (6) send_sequence();
      req_gaps_on = 1'b1;
   endtask

   task automatic test_seconds_wrap();
      send_item(smts_pkg::OP_SYNC, 32'd0, 30'd0, 32'hFFFF_FFFF, 30'd999_999_998);
      read_time(32'd0, 30'd1);
      read_time(32'd0, 30'd2);
      read_time(32'd5, 30'd0);
      repeat (10) read_time($urandom, rand_nsec());
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= smts_pkg::OP_SYNC;
      req_ch.sys_sec <= '0;
      req_ch.sys_nsec <= '0;
      req_ch.ref_sec <= '0;
      req_ch.ref_nsec <= '0;
      epoch_model = smts_pkg::EpochReset;
      synced_seen = 1'b0;
      anchor_sys_sec = '0;
      anchor_sys_nsec = '0;
      anchor_ref_sec = '0;
      anchor_ref_nsec = '0;
      reported_sec = '0;
      reported_nsec = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unsynced_reads();
      test_epoch_offset_extremes();
      test_unsynced_random();
      test_sync_arithmetic();
      test_random_sequences();
      test_result_backpressure();
      test_seconds_wrap();

      req_ch.valid <= 1'b0;
      for (int n = 0; n < 5000 && expected_stamps.size() != 0; n++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_stamps.size() != 0) begin
         $error("%0d results never arrived", expected_stamps.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("PASS synced_monotonic_timestamp");
      end else begin
         $display("FAIL synced_monotonic_timestamp");
      end
      $finish;
   end

   // result side ready, with random and long stalls
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         n = 0;
         if (long_stall_cycles > 0) begin
            n = long_stall_cycles;
            long_stall_cycles = 0;
         end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
            n = pick_idle();
         end
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      stamp_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_stamps.size() == 0) begin
            $error("result with no item pending: sec %0d nsec %0d",
                   rsp_ch.out_sec, rsp_ch.out_nsec);
            mismatches++;
         end else begin
            e = expected_stamps.pop_front();
            if (rsp_ch.out_sec !== e.sec) begin
               $error("out_sec expected %0d actual %0d", e.sec, rsp_ch.out_sec);
               mismatches++;
            end
            if (rsp_ch.out_nsec !== e.nsec) begin
               $error("out_nsec expected %0d actual %0d", e.nsec, rsp_ch.out_nsec);
               mismatches++;
            end
            if (rsp_ch.held !== e.held) begin
               $error("held expected %0d actual %0d", e.held, rsp_ch.held);
               mismatches++;
            end
            if (rsp_ch.set_clock !== e.set_clock) begin
               $error("set_clock expected %0d actual %0d", e.set_clock, rsp_ch.set_clock);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL synced_monotonic_timestamp");
      $finish;
   end

endmodule

// File: sim.f
design/smts_pkg.sv
design/smts_if.sv
design/smts_in_stage.sv
design/smts_core.sv
design/synced_monotonic_timestamp.sv
test/tb_synced_monotonic_timestamp.sv
